>>> design/psh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psh_pkg
// Types and constants shared by the point-to-segment hit test.
// ----------------------------------------------------------------------------
package psh_pkg;

    localparam int COORD_W     = 24;
    localparam int TOL_W       = 16;
    localparam int T_FRAC_BITS = 16;
    localparam int POS_W       = T_FRAC_BITS + 1;
    localparam int DIFF_W      = COORD_W + 1;
    localparam int SQ_W        = 2 * DIFF_W;
    localparam int QUO_W       = 2 * T_FRAC_BITS + 1;
    localparam int DIV_STEPS   = 2 * T_FRAC_BITS;
    localparam int ROOT_W      = (QUO_W + 1) / 2;
    localparam int RAD_W       = 2 * ROOT_W;
    localparam int REM_W       = ROOT_W + 3;
    localparam int PADDR_W     = 3;

    localparam logic REG_TOLERANCE = 1'b0;
    localparam logic [TOL_W-1:0] TOL_RESET = 16'd1024;

    typedef struct packed {
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
    } psh_in_t;

    typedef struct packed {
        logic             hit;
        logic [POS_W-1:0] position_t;
    } psh_out_t;

    typedef struct packed {
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic signed [DIFF_W-1:0] lx;
        logic signed [DIFF_W-1:0] ly;
        logic                     early_hit;
        logic                     early_end;
        logic                     do_div;
    } psh_ctx_t;

endpackage
`default_nettype wire

>>> design/psh_div_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psh_div_cell
// One restoring division step: produces one quotient bit per cell.
// ----------------------------------------------------------------------------
module psh_div_cell (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       en,
    input  wire logic                       in_vld,
    input  wire psh_pkg::psh_ctx_t          in_ctx,
    input  wire logic [psh_pkg::SQ_W-1:0]   in_rem,
    input  wire logic [psh_pkg::SQ_W-1:0]   in_den,
    input  wire logic [psh_pkg::QUO_W-1:0]  in_quo,
    output logic                            out_vld,
    output psh_pkg::psh_ctx_t               out_ctx,
    output logic [psh_pkg::SQ_W-1:0]        out_rem,
    output logic [psh_pkg::SQ_W-1:0]        out_den,
    output logic [psh_pkg::QUO_W-1:0]       out_quo
);
    import psh_pkg::*;

    logic [SQ_W:0] rem2;
    logic [SQ_W:0] diff;
    logic          ge;

    assign rem2 = {in_rem, 1'b0};
    assign diff = rem2 - {1'b0, in_den};
    assign ge   = rem2 >= {1'b0, in_den};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld <= 1'b0;
        end else if (en) begin
            out_vld <= in_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_ctx <= in_ctx;
            out_den <= in_den;
            out_rem <= ge ? diff[SQ_W-1:0] : rem2[SQ_W-1:0];
            out_quo <= {in_quo[QUO_W-2:0], ge};
        end
    end

endmodule
`default_nettype wire

>>> design/psh_sqrt_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psh_sqrt_cell
// One digit-by-digit square root step: produces one root bit per cell.
// ----------------------------------------------------------------------------
module psh_sqrt_cell (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        en,
    input  wire logic                        in_vld,
    input  wire psh_pkg::psh_ctx_t           in_ctx,
    input  wire logic [psh_pkg::RAD_W-1:0]   in_rad,
    input  wire logic [psh_pkg::REM_W-1:0]   in_rem,
    input  wire logic [psh_pkg::ROOT_W-1:0]  in_root,
    output logic                             out_vld,
    output psh_pkg::psh_ctx_t                out_ctx,
    output logic [psh_pkg::RAD_W-1:0]        out_rad,
    output logic [psh_pkg::REM_W-1:0]        out_rem,
    output logic [psh_pkg::ROOT_W-1:0]       out_root
);
    import psh_pkg::*;

    logic [REM_W-1:0] rs;
    logic [REM_W-1:0] trial;
    logic             ge;

    assign rs    = {in_rem[REM_W-3:0], in_rad[RAD_W-1 -: 2]};
    assign trial = {1'b0, in_root, 2'b01};
    assign ge    = rs >= trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld <= 1'b0;
        end else if (en) begin
            out_vld <= in_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_ctx  <= in_ctx;
            out_rad  <= {in_rad[RAD_W-3:0], 2'b00};
            out_rem  <= ge ? rs - trial : rs;
            out_root <= {in_root[ROOT_W-2:0], ge};
        end
    end

endmodule
`default_nettype wire

>>> design/point_segment_hit_test.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// point_segment_hit_test
// Tests whether a query point lies within a programmable tolerance of a
// segment and reports the fraction along the segment at a hit.
// ----------------------------------------------------------------------------
//  Channel   Ports            Direction  Beat
//  input     s_valid/s_ready  in         segment and query point
//  result    m_valid/m_ready  out        hit flag and position
//  config    APB (psel...)    in/out     tolerance register
//
//  One beat is accepted per cycle while the pipeline is not held. An
//  accepted beat passes 3 front stages, a setup stage, 32 divider cells,
//  17 root cells and 3 back stages, which feed the output register.
//  The whole pipeline holds when the output register is full and not taken,
//  unless the last stage is empty. Reset is synchronous, clears valid bits
//  and loads the tolerance register with TOL_RESET.
// ----------------------------------------------------------------------------
module point_segment_hit_test (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire psh_pkg::psh_in_t              s_data,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output psh_pkg::psh_out_t                  m_data,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [psh_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import psh_pkg::*;

    logic [TOL_W-1:0]   tol_reg;
    logic [2*TOL_W-1:0] tol_sq_reg;
    logic               adv;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_TOLERANCE) ? {16'd0, tol_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= TOL_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_TOLERANCE) begin
            tol_reg <= pwdata[TOL_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        tol_sq_reg <= tol_reg * tol_reg;
    end

    // Stage 1: differences.
    logic                     s1_vld_reg;
    logic signed [DIFF_W-1:0] s1_dx_reg, s1_dy_reg, s1_lx_reg, s1_ly_reg;
    logic signed [DIFF_W-1:0] s1_ex_reg, s1_ey_reg;

    // Stage 2: squares and box test.
    logic                     s2_vld_reg;
    psh_ctx_t                 s2_ctx_reg;
    logic                     s2_box_reg;
    logic [SQ_W-2:0]          s2_dx2_reg, s2_dy2_reg, s2_lx2_reg, s2_ly2_reg;
    logic [SQ_W-2:0]          s2_ex2_reg, s2_ey2_reg;

    // Stage 3: squared lengths.
    logic                     s3_vld_reg;
    psh_ctx_t                 s3_ctx_reg;
    logic                     s3_box_reg;
    logic [SQ_W-1:0]          s3_sp_reg, s3_sl_reg, s3_pb_reg;

    logic                     m_valid_reg;
    psh_out_t                 m_data_reg;

    logic                     b3_vld_reg;

    assign adv     = m_ready || !m_valid_reg || !b3_vld_reg;
    assign s_ready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end else if (adv) begin
            s1_vld_reg <= s_valid;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
        end
    end

    logic signed [DIFF_W+1:0] tol_s, lo_x, hi_x, lo_y, hi_y;
    logic signed [SQ_W-1:0]   p_dx, p_dy, p_lx, p_ly, p_ex, p_ey;
    psh_ctx_t                 s2_ctx_next;

    always_comb begin
        tol_s = signed'({{(DIFF_W+2-TOL_W){1'b0}}, tol_reg});
        lo_x  = (s1_lx_reg[DIFF_W-1] ? (DIFF_W+2)'(s1_lx_reg) : '0) - tol_s;
        hi_x  = (s1_lx_reg[DIFF_W-1] ? '0 : (DIFF_W+2)'(s1_lx_reg)) + tol_s;
        lo_y  = (s1_ly_reg[DIFF_W-1] ? (DIFF_W+2)'(s1_ly_reg) : '0) - tol_s;
        hi_y  = (s1_ly_reg[DIFF_W-1] ? '0 : (DIFF_W+2)'(s1_ly_reg)) + tol_s;
        p_dx  = s1_dx_reg * s1_dx_reg;
        p_dy  = s1_dy_reg * s1_dy_reg;
        p_lx  = s1_lx_reg * s1_lx_reg;
        p_ly  = s1_ly_reg * s1_ly_reg;
        p_ex  = s1_ex_reg * s1_ex_reg;
        p_ey  = s1_ey_reg * s1_ey_reg;
        s2_ctx_next           = '0;
        s2_ctx_next.dx        = s1_dx_reg;
        s2_ctx_next.dy        = s1_dy_reg;
        s2_ctx_next.lx        = s1_lx_reg;
        s2_ctx_next.ly        = s1_ly_reg;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_dx_reg  <= {s_data.point_x[COORD_W-1], s_data.point_x}
                        - {s_data.start_x[COORD_W-1], s_data.start_x};
            s1_dy_reg  <= {s_data.point_y[COORD_W-1], s_data.point_y}
                        - {s_data.start_y[COORD_W-1], s_data.start_y};
            s1_lx_reg  <= {s_data.end_x[COORD_W-1], s_data.end_x}
                        - {s_data.start_x[COORD_W-1], s_data.start_x};
            s1_ly_reg  <= {s_data.end_y[COORD_W-1], s_data.end_y}
                        - {s_data.start_y[COORD_W-1], s_data.start_y};
            s1_ex_reg  <= {s_data.point_x[COORD_W-1], s_data.point_x}
                        - {s_data.end_x[COORD_W-1], s_data.end_x};
            s1_ey_reg  <= {s_data.point_y[COORD_W-1], s_data.point_y}
                        - {s_data.end_y[COORD_W-1], s_data.end_y};

            s2_ctx_reg <= s2_ctx_next;
            s2_box_reg <= ((DIFF_W+2)'(s1_dx_reg) >= lo_x) && ((DIFF_W+2)'(s1_dx_reg) <= hi_x)
                       && ((DIFF_W+2)'(s1_dy_reg) >= lo_y) && ((DIFF_W+2)'(s1_dy_reg) <= hi_y);
            s2_dx2_reg <= p_dx[SQ_W-2:0];
            s2_dy2_reg <= p_dy[SQ_W-2:0];
            s2_lx2_reg <= p_lx[SQ_W-2:0];
            s2_ly2_reg <= p_ly[SQ_W-2:0];
            s2_ex2_reg <= p_ex[SQ_W-2:0];
            s2_ey2_reg <= p_ey[SQ_W-2:0];

            s3_ctx_reg <= s2_ctx_reg;
            s3_box_reg <= s2_box_reg;
            s3_sp_reg  <= {1'b0, s2_dx2_reg} + {1'b0, s2_dy2_reg};
            s3_sl_reg  <= {1'b0, s2_lx2_reg} + {1'b0, s2_ly2_reg};
            s3_pb_reg  <= {1'b0, s2_ex2_reg} + {1'b0, s2_ey2_reg};
        end
    end

    // Stage 4: classification and divider setup.
    logic [SQ_W-1:0] tol_sq_w;
    logic            near_a, past_b, near_b;
    psh_ctx_t        d0_ctx_next;
    logic            q0;

    always_comb begin
        tol_sq_w    = {{(SQ_W-2*TOL_W){1'b0}}, tol_sq_reg};
        near_a      = s3_sp_reg < tol_sq_w;
        past_b      = s3_sp_reg > s3_sl_reg;
        near_b      = s3_pb_reg < tol_sq_w;
        q0          = s3_sp_reg >= s3_sl_reg;
        d0_ctx_next = s3_ctx_reg;
        d0_ctx_next.early_hit = 1'b0;
        d0_ctx_next.early_end = 1'b0;
        d0_ctx_next.do_div    = 1'b0;
        if (s3_box_reg) begin
            if (near_a) begin
                d0_ctx_next.early_hit = 1'b1;
            end else if (past_b) begin
                d0_ctx_next.early_hit = near_b;
                d0_ctx_next.early_end = 1'b1;
            end else begin
                d0_ctx_next.do_div = s3_sl_reg != '0;
            end
        end
    end

    logic              d_vld [DIV_STEPS+1];
    psh_ctx_t          d_ctx [DIV_STEPS+1];
    logic [SQ_W-1:0]   d_rem [DIV_STEPS+1];
    logic [SQ_W-1:0]   d_den [DIV_STEPS+1];
    logic [QUO_W-1:0]  d_quo [DIV_STEPS+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_vld[0] <= 1'b0;
        end else if (adv) begin
            d_vld[0] <= s3_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            d_ctx[0] <= d0_ctx_next;
            d_den[0] <= s3_sl_reg;
            d_rem[0] <= q0 ? '0 : s3_sp_reg;
            d_quo[0] <= {{(QUO_W-1){1'b0}}, q0};
        end
    end

    for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
        psh_div_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (adv),
            .in_vld  (d_vld[i]),
            .in_ctx  (d_ctx[i]),
            .in_rem  (d_rem[i]),
            .in_den  (d_den[i]),
            .in_quo  (d_quo[i]),
            .out_vld (d_vld[i+1]),
            .out_ctx (d_ctx[i+1]),
            .out_rem (d_rem[i+1]),
            .out_den (d_den[i+1]),
            .out_quo (d_quo[i+1])
        );
    end

    logic              r_vld  [ROOT_W+1];
    psh_ctx_t          r_ctx  [ROOT_W+1];
    logic [RAD_W-1:0]  r_rad  [ROOT_W+1];
    logic [REM_W-1:0]  r_rem  [ROOT_W+1];
    logic [ROOT_W-1:0] r_root [ROOT_W+1];

    assign r_vld[0]  = d_vld[DIV_STEPS];
    assign r_ctx[0]  = d_ctx[DIV_STEPS];
    assign r_rad[0]  = {{(RAD_W-QUO_W){1'b0}}, d_quo[DIV_STEPS]};
    assign r_rem[0]  = '0;
    assign r_root[0] = '0;

    for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
        psh_sqrt_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (adv),
            .in_vld   (r_vld[j]),
            .in_ctx   (r_ctx[j]),
            .in_rad   (r_rad[j]),
            .in_rem   (r_rem[j]),
            .in_root  (r_root[j]),
            .out_vld  (r_vld[j+1]),
            .out_ctx  (r_ctx[j+1]),
            .out_rad  (r_rad[j+1]),
            .out_rem  (r_rem[j+1]),
            .out_root (r_root[j+1])
        );
    end

    // Back end: scale the segment by t, form the residual and compare.
    logic                        b1_vld_reg, b2_vld_reg;
    psh_ctx_t                    b1_ctx_reg, b2_ctx_reg, b3_ctx_reg;
    logic [ROOT_W-1:0]           b1_t_reg, b2_t_reg, b3_t_reg;
    logic [DIFF_W+ROOT_W-1:0]    b1_px_reg, b1_py_reg;
    logic signed [DIFF_W+1:0]    b2_rx_reg, b2_ry_reg;
    logic [2*DIFF_W+3:0]         b3_rx2_reg, b3_ry2_reg;

    logic [DIFF_W-1:0]           mag_x, mag_y;
    logic [DIFF_W+ROOT_W-1:0]    rnd_x, rnd_y;
    logic [DIFF_W-1:0]           sc_x, sc_y;
    logic signed [DIFF_W+1:0]    sx, sy;
    logic signed [2*DIFF_W+3:0]  q_x, q_y;

    always_comb begin
        mag_x = r_ctx[ROOT_W].lx[DIFF_W-1] ? DIFF_W'(-r_ctx[ROOT_W].lx) : r_ctx[ROOT_W].lx;
        mag_y = r_ctx[ROOT_W].ly[DIFF_W-1] ? DIFF_W'(-r_ctx[ROOT_W].ly) : r_ctx[ROOT_W].ly;
        rnd_x = b1_px_reg + (DIFF_W+ROOT_W)'(1 << (T_FRAC_BITS - 1));
        rnd_y = b1_py_reg + (DIFF_W+ROOT_W)'(1 << (T_FRAC_BITS - 1));
        sc_x  = rnd_x[T_FRAC_BITS +: DIFF_W];
        sc_y  = rnd_y[T_FRAC_BITS +: DIFF_W];
        sx    = signed'({2'b00, sc_x});
        sy    = signed'({2'b00, sc_y});
        q_x   = b2_rx_reg * b2_rx_reg;
        q_y   = b2_ry_reg * b2_ry_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1_vld_reg <= 1'b0;
            b2_vld_reg <= 1'b0;
            b3_vld_reg <= 1'b0;
        end else if (adv) begin
            b1_vld_reg <= r_vld[ROOT_W];
            b2_vld_reg <= b1_vld_reg;
            b3_vld_reg <= b2_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            b1_ctx_reg <= r_ctx[ROOT_W];
            b1_t_reg   <= r_root[ROOT_W];
            b1_px_reg  <= mag_x * r_root[ROOT_W];
            b1_py_reg  <= mag_y * r_root[ROOT_W];

            b2_ctx_reg <= b1_ctx_reg;
            b2_t_reg   <= b1_t_reg;
            b2_rx_reg  <= (DIFF_W+2)'(b1_ctx_reg.dx) - (b1_ctx_reg.lx[DIFF_W-1] ? -sx : sx);
            b2_ry_reg  <= (DIFF_W+2)'(b1_ctx_reg.dy) - (b1_ctx_reg.ly[DIFF_W-1] ? -sy : sy);

            b3_ctx_reg <= b2_ctx_reg;
            b3_t_reg   <= b2_t_reg;
            b3_rx2_reg <= q_x;
            b3_ry2_reg <= q_y;
        end
    end

    logic [2*DIFF_W+4:0] res_sq;
    psh_out_t            res;

    always_comb begin
        res_sq = {1'b0, b3_rx2_reg} + {1'b0, b3_ry2_reg};
        res    = '0;
        if (b3_ctx_reg.do_div) begin
            if (res_sq < (2*DIFF_W+5)'(tol_sq_reg)) begin
                res.hit        = 1'b1;
                res.position_t = b3_t_reg;
            end
        end else if (b3_ctx_reg.early_hit) begin
            res.hit        = 1'b1;
            res.position_t = b3_ctx_reg.early_end ? POS_W'(1 << T_FRAC_BITS) : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv && b3_vld_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && b3_vld_reg) begin
            m_data_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
`default_nettype wire

>>> design/psh_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psh_checker
// Port-level checks on the result channel and the configuration port of the hit test.
// ----------------------------------------------------------------------------
module psh_checker (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               m_valid,
    input  wire logic               m_ready,
    input  wire psh_pkg::psh_out_t  m_data,
    input  wire logic               pready
);
    import psh_pkg::*;

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("Result beat dropped before it was taken.");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_data))
        else $error("Result beat changed while stalled.");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.hit |-> m_data.position_t == '0)
        else $error("Miss reported with a nonzero position.");

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.position_t <= POS_W'(1 << T_FRAC_BITS))
        else $error("Position above one.");

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("Configuration port inserted a wait state.");

endmodule

bind point_segment_hit_test psh_checker u_psh_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data),
    .pready  (pready)
);
`default_nettype wire
